>>> rtl/pdce_pkg.sv
// Shared constants for the parallel-bus DMA cycle estimator.
package pdce_pkg;

	localparam int LENGTH_WIDTH_DEF = 24;
	localparam int ADDR_W           = 32;
	localparam int TOTAL_W          = 32;

	// configuration port
	localparam int CFG_DATA_W  = 8;
	localparam int CFG_INDEX_W = 3;
	localparam int LAT_W       = 8;
	localparam int PULSE_W     = 8;
	localparam int CODE_W      = 4;
	localparam int REL_W       = 2;

	localparam logic [CFG_INDEX_W-1:0] CFG_DOM1_LATENCY = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_DOM1_PULSE   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_DOM1_PAGE    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_DOM1_RELEASE = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_DOM2_LATENCY = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_DOM2_PULSE   = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] CFG_DOM2_PAGE    = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] CFG_DOM2_RELEASE = 3'd7;

	// timing domains
	localparam int DOM1 = 0;
	localparam int DOM2 = 1;
	localparam logic [7:0] REGION_DOM2_SOLO  = 8'd5;
	localparam logic [4:0] REGION_DOM2_BLOCK = 5'd1;   // regions 8..15 share bits 7..3

	// page geometry: page = 4 << code, so the shift is 2..17
	localparam int PAGE_SHIFT_BASE = 2;
	localparam int SHIFT_W         = 5;
	localparam int PAGE_OFS_W      = 17;
	localparam int PAGE_W          = PAGE_OFS_W + 1;

	// cost terms
	localparam int FAC_W            = 9;
	localparam int PAGE_BASE_CYCLES = 15;
	localparam int STROBE_EXTRA     = 2;
	localparam int BUFFER_BYTES     = 128;
	localparam int BUFFER_LOG2      = 7;
	localparam int BUFFER_PENALTY   = 28;

endpackage

>>> rtl/parallel_dma_cycle_estimator_unit.sv
// Top level: four-stage pipeline that estimates parallel-bus DMA cycle counts.
//
//  channel  | direction | payload
//  ---------+-----------+-----------------------------------------------------
//  s_axis   | in        | tdata: start_addr, length_minus_one
//  m_axis   | out       | tdata: total_cycles
//  cfg      | in        | cfg_we, cfg_index (register 0..7), cfg_wdata
//
//  One item per cycle while m_axis does not stall, through four register stages:
//  domain select, page span, multiply, sum and saturate.
//  Stage four is the output register; a waiting result blocks the input only once
//  stages one to three are full as well.
//  A stall on m_axis holds stage four; a stage above holds only while all below are full.
//  arst_n clears all valid bits and the timing registers, which reset to zero.
module parallel_dma_cycle_estimator_unit #(
	parameter int LENGTH_WIDTH = pdce_pkg::LENGTH_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,

	input  logic                                        s_axis_tvalid,
	output logic                                        s_axis_tready,
	// [31:0] start_addr, [31+LENGTH_WIDTH:32] length_minus_one, zero fill above
	input  logic [((pdce_pkg::ADDR_W+LENGTH_WIDTH+7)/8)*8-1:0] s_axis_tdata,

	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [31:0] total_cycles
	output logic [pdce_pkg::TOTAL_W-1:0]   m_axis_tdata,

	input  logic                               cfg_we,
	input  logic [pdce_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [pdce_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	localparam int AW      = pdce_pkg::ADDR_W;
	localparam int OFS_W   = pdce_pkg::PAGE_OFS_W;
	localparam int PGSZ_W  = pdce_pkg::PAGE_W;
	localparam int FAC_W   = pdce_pkg::FAC_W;
	localparam int SH_W    = pdce_pkg::SHIFT_W;
	localparam int BW      = LENGTH_WIDTH + 1;
	localparam int END_W   = ((BW > OFS_W) ? BW : OFS_W) + 1;
	localparam int PG_W    = END_W - 1;
	localparam int MIDB_W  = END_W - pdce_pkg::BUFFER_LOG2;
	localparam int BUF_W   = MIDB_W + 1;
	localparam int PART_W  = (BW > OFS_W + 2) ? BW : OFS_W + 2;
	localparam int PA_W    = FAC_W + PG_W;
	localparam int PB_W    = FAC_W + LENGTH_WIDTH;
	localparam int SUM_W0  = PA_W + 2;
	localparam int SUM_W   = (SUM_W0 > pdce_pkg::TOTAL_W) ? SUM_W0 : pdce_pkg::TOTAL_W + 1;

	// ---------------- configuration registers ----------------
	logic [pdce_pkg::LAT_W-1:0]   lat_q   [2];
	logic [pdce_pkg::PULSE_W-1:0] pulse_q [2];
	logic [pdce_pkg::CODE_W-1:0]  code_q  [2];
	logic [pdce_pkg::REL_W-1:0]   rel_q   [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_q   <= '{default: '0};
			pulse_q <= '{default: '0};
			code_q  <= '{default: '0};
			rel_q   <= '{default: '0};
		end else if (cfg_we) begin
			case (cfg_index)
				pdce_pkg::CFG_DOM1_LATENCY: lat_q[pdce_pkg::DOM1]   <= cfg_wdata;
				pdce_pkg::CFG_DOM1_PULSE:   pulse_q[pdce_pkg::DOM1] <= cfg_wdata;
				pdce_pkg::CFG_DOM1_PAGE:    code_q[pdce_pkg::DOM1]  <= cfg_wdata[pdce_pkg::CODE_W-1:0];
				pdce_pkg::CFG_DOM1_RELEASE: rel_q[pdce_pkg::DOM1]   <= cfg_wdata[pdce_pkg::REL_W-1:0];
				pdce_pkg::CFG_DOM2_LATENCY: lat_q[pdce_pkg::DOM2]   <= cfg_wdata;
				pdce_pkg::CFG_DOM2_PULSE:   pulse_q[pdce_pkg::DOM2] <= cfg_wdata;
				pdce_pkg::CFG_DOM2_PAGE:    code_q[pdce_pkg::DOM2]  <= cfg_wdata[pdce_pkg::CODE_W-1:0];
				pdce_pkg::CFG_DOM2_RELEASE: rel_q[pdce_pkg::DOM2]   <= cfg_wdata[pdce_pkg::REL_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- stall chain ----------------
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic en1, en2, en3, en4;

	assign en4 = !valid_s4 || m_axis_tready;
	assign en3 = !valid_s3 || en4;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign s_axis_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= s_axis_tvalid;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
			if (en4) valid_s4 <= valid_s3;
		end
	end

	// ---------------- stage 1: domain, page shift, offset ----------------
	logic [AW-1:0]           addr;
	logic [LENGTH_WIDTH-1:0] len;
	logic                    dom2;
	logic                    dsel;
	logic [SH_W-1:0]         shift_in;
	logic [OFS_W-1:0]        mask_in;

	assign addr = s_axis_tdata[AW-1:0];
	assign len  = s_axis_tdata[AW +: LENGTH_WIDTH];
	assign dom2 = (addr[31:24] == pdce_pkg::REGION_DOM2_SOLO)
	           || (addr[31:27] == pdce_pkg::REGION_DOM2_BLOCK);
	assign dsel = dom2;
	assign shift_in = SH_W'(code_q[dsel]) + SH_W'(pdce_pkg::PAGE_SHIFT_BASE);
	assign mask_in  = ~({OFS_W{1'b1}} << shift_in);

	logic [SH_W-1:0]         shift_s1;
	logic [OFS_W-1:0]        mask_s1;
	logic [OFS_W-1:0]        offset_s1;
	logic [LENGTH_WIDTH-1:0] lenor_s1;   // bytes - 1, with bytes rounded up to even
	logic [LENGTH_WIDTH-1:0] hw_s1;      // halfwords = bytes / 2, rounded up
	logic [FAC_W-1:0]        latf_s1;
	logic [FAC_W-1:0]        hwf_s1;

	always_ff @(posedge clk) begin
		if (en1 && s_axis_tvalid) begin
			shift_s1  <= shift_in;
			mask_s1   <= mask_in;
			offset_s1 <= addr[OFS_W-1:0] & mask_in;
			lenor_s1  <= len | LENGTH_WIDTH'(1);
			hw_s1     <= (len >> 1) + LENGTH_WIDTH'(1);
			latf_s1   <= FAC_W'(lat_q[dsel]) + FAC_W'(pdce_pkg::PAGE_BASE_CYCLES);
			hwf_s1    <= FAC_W'(pulse_q[dsel]) + FAC_W'(rel_q[dsel])
			           + FAC_W'(pdce_pkg::STROBE_EXTRA);
		end
	end

	// ---------------- stage 2: page span ----------------
	logic [END_W-1:0]  endm1;
	logic [END_W-1:0]  mask_ext;
	logic [PGSZ_W-1:0] page;

	assign endm1    = END_W'(offset_s1) + END_W'(lenor_s1);
	assign mask_ext = END_W'(mask_s1);
	assign page     = PGSZ_W'(1) << shift_s1;

	logic [PG_W-1:0]         pages_s2;
	logic [OFS_W-1:0]        tail_s2;
	logic                    ofs_zero_s2;
	logic [PGSZ_W-1:0]       head_s2;
	logic [END_W-1:0]        mid_s2;
	logic [LENGTH_WIDTH-1:0] hw_s2;
	logic [FAC_W-1:0]        latf_s2;
	logic [FAC_W-1:0]        hwf_s2;

	always_ff @(posedge clk) begin
		if (en2 && valid_s1) begin
			pages_s2    <= PG_W'(endm1 >> shift_s1) + PG_W'(1);
			tail_s2     <= (endm1[OFS_W-1:0] + OFS_W'(1)) & mask_s1;
			ofs_zero_s2 <= (offset_s1 == '0);
			head_s2     <= page - PGSZ_W'(offset_s1);
			// bytes in whole pages strictly between the first and the last
			mid_s2      <= (endm1 & ~mask_ext) - END_W'(page);
			hw_s2       <= hw_s1;
			latf_s2     <= latf_s1;
			hwf_s2      <= hwf_s1;
		end
	end

	// ---------------- stage 3: buffers, partial bytes, products ----------------
	logic [BW-1:0]     bytes2;
	logic              single;
	logic [BUF_W-1:0]  buf_n;
	logic [PART_W-1:0] part_n;

	assign bytes2 = {hw_s2, 1'b0};
	assign single = (pages_s2 == PG_W'(1));

	always_comb begin
		if (single) begin
			buf_n  = BUF_W'(bytes2 == BW'(pdce_pkg::BUFFER_BYTES));
			part_n = (bytes2 == BW'(pdce_pkg::BUFFER_BYTES)) ? '0 : PART_W'(bytes2);
		end else begin
			buf_n  = BUF_W'(mid_s2[END_W-1:pdce_pkg::BUFFER_LOG2])
			       + BUF_W'(ofs_zero_s2) + BUF_W'(tail_s2 == '0);
			part_n = (ofs_zero_s2 ? '0 : PART_W'(head_s2)) + PART_W'(tail_s2);
		end
	end

	logic [BUF_W-1:0]  buf_s3;
	logic [PART_W-1:0] part_s3;
	logic [PA_W-1:0]   pa_s3;
	logic [PB_W-1:0]   pb_s3;

	always_ff @(posedge clk) begin
		if (en3 && valid_s2) begin
			buf_s3  <= buf_n;
			part_s3 <= part_n;
			pa_s3   <= PA_W'(latf_s2) * PA_W'(pages_s2);
			pb_s3   <= PB_W'(hwf_s2) * PB_W'(hw_s2);
		end
	end

	// ---------------- stage 4: sum and saturate ----------------
	logic [SUM_W-1:0] sum;

	assign sum = SUM_W'(pa_s3) + SUM_W'(pb_s3)
	           + SUM_W'(buf_s3) * SUM_W'(pdce_pkg::BUFFER_PENALTY)
	           + SUM_W'(part_s3);

	logic [pdce_pkg::TOTAL_W-1:0] total_s4;

	always_ff @(posedge clk) begin
		if (en4 && valid_s3) begin
			total_s4 <= (|sum[SUM_W-1:pdce_pkg::TOTAL_W]) ? '1 : sum[pdce_pkg::TOTAL_W-1:0];
		end
	end

	assign m_axis_tvalid = valid_s4;
	assign m_axis_tdata  = total_s4;

endmodule

>>> rtl/pdce_checker.sv
// Port-level checks for the DMA cycle estimator, bound to its top level.
module pdce_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_axis_tvalid,
	input logic                         s_axis_tready,
	input logic                         m_axis_tvalid,
	input logic                         m_axis_tready,
	input logic [pdce_pkg::TOTAL_W-1:0] m_axis_tdata
);

	// hold a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed or dropped");

	// input backpressure only comes from a stalled full output
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without an output stall");

	// with the output open, an accepted item passes stages one to four and reaches the output
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) ##1 m_axis_tready ##1 m_axis_tready
		##1 m_axis_tready |=> m_axis_tvalid)
		else $error("accepted item did not arrive after four cycles");

	// an empty output with nothing in flight stays empty
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid ##1 !m_axis_tvalid ##1 !m_axis_tvalid ##1 !m_axis_tvalid
		##0 $past(!(s_axis_tvalid && s_axis_tready), 1)
		&& $past(!(s_axis_tvalid && s_axis_tready), 2)
		&& $past(!(s_axis_tvalid && s_axis_tready), 3)
		&& !(s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
		else $error("result appeared with no item in flight");

endmodule

bind parallel_dma_cycle_estimator_unit pdce_checker u_pdce_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
